// ----- sv/three_phase_duty_scaler_assert.svh -----
// ----------------------------------------------------------------------------
// three_phase_duty_scaler assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_DUTY_SCALER_ASSERT_SVH
`define THREE_PHASE_DUTY_SCALER_ASSERT_SVH

// same-cycle implication
`define TPDS_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPDS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tpds_pkg.sv -----
// ----------------------------------------------------------------------------
// tpds_pkg
// Types and fixed codes shared by the duty scaler modules.
// ----------------------------------------------------------------------------
package tpds_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_SET  = 2'd0;
	localparam logic [1:0] REQ_LOW  = 2'd1;
	localparam logic [1:0] REQ_HIGH = 2'd2;

	// configuration register indexes
	localparam logic REG_PERIOD     = 1'b0;
	localparam logic REG_INIT_BOUND = 1'b1;

	localparam int          PERIOD_RESET = 10000;
	localparam logic [1:0]  LAST_PHASE   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUND,
		ST_LOAD,
		ST_STEP,
		ST_STORE,
		ST_DONE
	} tpds_state_t;

	// sequencer commands to the scaling unit
	typedef struct packed {
		logic load;
		logic step;
	} tpds_ctl_t;

endpackage

// ----- sv/tpds_scale_unit.sv -----
// ----------------------------------------------------------------------------
// tpds_scale_unit
// Shift-add-divide step: floor(period * n / d), one period bit per step.
// ----------------------------------------------------------------------------
module tpds_scale_unit
	import tpds_pkg::*;
#(
	parameter int PW = 24,
	parameter int QW = 16
) (
	input  logic          clk,
	input  tpds_ctl_t     ctl,
	input  logic [PW:0]   n_in,
	input  logic [PW:0]   d_in,
	input  logic          pbit,
	output logic [QW-1:0] q_out
);

	logic [PW:0]   n_q;
	logic [PW:0]   d_q;
	logic [PW:0]   r_q;
	logic [QW-1:0] q_q;

	logic [PW+1:0] r2;
	logic [PW+1:0] d1;
	logic [PW+1:0] d2;
	logic          ge1;
	logic          ge2;
	logic [PW+1:0] r_red;
	logic [1:0]    k;

	// r stays below d, so 2r + n stays below 3d: one of three outcomes
	assign d1  = {1'b0, d_q};
	assign d2  = {d_q, 1'b0};
	assign r2  = {r_q, 1'b0} + {1'b0, (pbit ? n_q : '0)};
	assign ge1 = (r2 >= d1);
	assign ge2 = (r2 >= d2);

	always_comb begin
		priority if (ge2) begin
			r_red = r2 - d2;
			k     = 2'd2;
		end else if (ge1) begin
			r_red = r2 - d1;
			k     = 2'd1;
		end else begin
			r_red = r2;
			k     = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			n_q <= n_in;
			d_q <= d_in;
			r_q <= '0;
			q_q <= '0;
		end else if (ctl.step) begin
			r_q <= r_red[PW:0];
			q_q <= {q_q[QW-2:0], 1'b0} + QW'(k);
		end
	end

	assign q_out = q_q;

endmodule

// ----- sv/three_phase_duty_scaler.sv -----
// ----------------------------------------------------------------------------
// three_phase_duty_scaler
// Three signed phase drives to PWM compare values with a peak-hold bound.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per transaction: s_tuser is the request kind
//   (set, force low, force high), s_tdata the three phases and the mask.
//   m_* returns one transaction per request: the three stored compare
//   values and the current peak bound.
//   cfg_we/cfg_index/cfg_wdata write period (0) or initial bound (1); write
//   only while no request is in flight.
// Sequence:
//   Set request: the accept, a bound scan over the three phases, then for
//   each phase a load, the scaling steps in the shared shift-add-divide
//   unit (one period bit a cycle) and a store, then the output state. A zero
//   bound set and a force or unused request skip to the output state.
//   s_tready is high only between requests.
// Reset:
//   Compare store and peak bound clear to zero, period to 10000, initial
//   bound to zero. Nothing in flight.
// Backpressure:
//   The result register holds while m_tready is low; a new request may be
//   taken meanwhile, and its result waits in the last state until the
//   register frees up.
// ----------------------------------------------------------------------------
module three_phase_duty_scaler
	import tpds_pkg::*;
#(
	parameter int PHASE_WIDTH  = 24,
	parameter int PERIOD_WIDTH = 16,
	localparam int IN_BITS  = 3 * PHASE_WIDTH + 3,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 3 * PERIOD_WIDTH + PHASE_WIDTH,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
	localparam int CFG_W    = (PERIOD_WIDTH > PHASE_WIDTH - 1) ? PERIOD_WIDTH
	                                                          : PHASE_WIDTH - 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // phase_a, phase_b, phase_c, phase_mask
	input  logic [1:0]       s_tuser,   // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // cmp_a, cmp_b, cmp_c, bound_now
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int PW = PHASE_WIDTH;
	localparam int QW = PERIOD_WIDTH;
	localparam int CW = $clog2(QW);

	tpds_state_t state_q, state_d;
	tpds_ctl_t   ctl;

	logic [QW-1:0]       period_q;
	logic [PW-2:0]       init_q;
	logic [PW-1:0]       peak_q;
	logic [PW-1:0]       bound_q;
	logic [2:0][PW-1:0]  ph_q;
	logic [2:0][QW-1:0]  cmp_q;
	logic [1:0]          idx_q;
	logic [CW-1:0]       cnt_q;
	logic [OUT_BITS-1:0] out_q;
	logic                out_vld_q;

	logic          in_acc;
	logic          out_load;
	logic          last_idx;
	logic [PW-1:0] ph_sel;
	logic [PW-1:0] mag_sel;
	logic [PW-1:0] bound_grow;
	logic [PW-1:0] base_bound;
	logic [PW:0]   n_in;
	logic [PW:0]   d_in;
	logic [QW-1:0] q_out;
	logic [2:0]    in_mask;

	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_tready);
	assign last_idx = (idx_q == LAST_PHASE);
	assign in_mask  = s_tdata[3*PW +: 3];

	// magnitude of the selected phase; most negative keeps 2^(PW-1)
	assign ph_sel     = ph_q[idx_q];
	assign mag_sel    = ph_sel[PW-1] ? (~ph_sel + 1'b1) : ph_sel;
	assign bound_grow = (mag_sel > bound_q) ? mag_sel : bound_q;
	assign base_bound = ({1'b0, init_q} > peak_q) ? {1'b0, init_q} : peak_q;

	// bound + phase lands in 0..2*bound since |phase| <= bound
	assign n_in = {1'b0, bound_q} + {ph_sel[PW-1], ph_sel};
	assign d_in = {bound_q, 1'b0};

	tpds_scale_unit #(
		.PW (PW),
		.QW (QW)
	) u_scale (
		.clk   (clk),
		.ctl   (ctl),
		.n_in  (n_in),
		.d_in  (d_in),
		.pbit  (period_q[cnt_q]),
		.q_out (q_out)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = (s_tuser == REQ_SET) ? ST_BOUND : ST_DONE;
			end
			ST_BOUND: begin
				if (last_idx)
					state_d = (bound_grow == '0) ? ST_DONE : ST_LOAD;
			end
			ST_LOAD:  state_d = ST_STEP;
			ST_STEP: begin
				if (cnt_q == '0)
					state_d = ST_STORE;
			end
			ST_STORE: state_d = last_idx ? ST_DONE : ST_LOAD;
			ST_DONE: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// state decodes
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ctl.load = (state_q == ST_LOAD);
		ctl.step = (state_q == ST_STEP);
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			period_q  <= QW'(PERIOD_RESET);
			init_q    <= '0;
			peak_q    <= '0;
			cmp_q     <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;

			if (cfg_we) begin
				if (cfg_index == REG_PERIOD)
					period_q <= cfg_wdata[QW-1:0];
				else
					init_q <= cfg_wdata[PW-2:0];
			end

			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc && (s_tuser == REQ_LOW || s_tuser == REQ_HIGH)) begin
						for (int i = 0; i < 3; i++) begin
							if (in_mask[i])
								cmp_q[i] <= (s_tuser == REQ_LOW) ? '0 : period_q;
						end
					end
				end
				ST_BOUND: begin
					if (last_idx) begin
						idx_q  <= '0;
						peak_q <= bound_grow;
						if (bound_grow == '0)
							cmp_q <= {3{period_q >> 1}};
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_LOAD:  cnt_q <= CW'(QW - 1);
				ST_STEP:  cnt_q <= cnt_q - 1'b1;
				ST_STORE: begin
					cmp_q[idx_q] <= q_out;
					idx_q        <= last_idx ? '0 : idx_q + 2'd1;
				end
				ST_DONE:  ;
				default:  ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ph_q[0] <= s_tdata[0 +: PW];
			ph_q[1] <= s_tdata[PW +: PW];
			ph_q[2] <= s_tdata[2*PW +: PW];
			bound_q <= base_bound;
		end else if (state_q == ST_BOUND) begin
			bound_q <= bound_grow;
		end
		if (out_load)
			out_q <= {peak_q, cmp_q[2], cmp_q[1], cmp_q[0]};
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'(out_q);

	`include "three_phase_duty_scaler_assert.svh"

	`TPDS_CHECK_NEXT(a_peak_hold, 1'b1, peak_q >= $past(peak_q), "peak bound decreased")
	`TPDS_CHECK(a_divisor_nonzero, ctl.load || ctl.step, bound_q != '0, "zero divisor")
	`TPDS_CHECK(a_cmp_in_range, state_q == ST_STORE, q_out <= period_q, "compare above period")

endmodule
